// ===== rtl/four_level_page_walk_defines.svh =====
// Assertion macros shared by the page walker RTL.
// Depends on nothing; the asserting module must have i_clk and i_rst_n.
`ifndef FOUR_LEVEL_PAGE_WALK_DEFINES_SVH
`define FOUR_LEVEL_PAGE_WALK_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FLPW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FLPW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/flpw_pkg.sv =====
// Types, constants and the microcode ROM of the four-level page walker.
// Depends on nothing; used by the top level, flpw_useq and flpw_dpath.
`default_nettype none

package flpw_pkg;

    localparam int TABLE_ENTRIES = 512;
    localparam int IDX_W         = 9;
    localparam int FRAME_W       = 40;
    localparam int PHYS_W        = 52;
    localparam int WIDX_W        = 14;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_XLATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_VALID = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 1'd1;

    typedef struct packed {
        logic                command;
        logic [63:0]         virt_addr;
        logic [WIDX_W-1:0]   word_index;
        logic [63:0]         word_data;
    } t_in_item;

    typedef struct packed {
        logic [PHYS_W-1:0]   phys_addr;
        logic                mapped;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_ROOT,
        ST_PML4,
        ST_PDPT,
        ST_PD,
        ST_PT
    } t_step;

    // Which slice of the virtual address indexes the table being read
    typedef enum logic [1:0] {
        LVL_PML4,
        LVL_PDPT,
        LVL_PD,
        LVL_PT
    } t_lvl;

    typedef struct packed {
        logic  dispatch;     // idle: branch on start and command
        logic  wr_en;        // store one table word
        logic  chk_root;     // root valid and canonical address
        logic  rd_en;        // read next table entry
        logic  rd_root;      // table base from root frame, else from entry
        t_lvl  idx_lvl;
        logic  chk_present;  // entry just read must be present
        logic  huge_en;      // page size bit ends the walk here
        logic  huge_1g;      // huge page is 1 GiB, else 2 MiB
        logic  leaf;         // entry just read is the 4 KiB leaf
        t_step next;
    } t_uop;

    typedef struct packed {
        logic finish;        // walk ends this step (mapped or fault)
    } t_stat;

    localparam t_uop UOP_NOP = '{
        dispatch: 1'b0, wr_en: 1'b0, chk_root: 1'b0, rd_en: 1'b0, rd_root: 1'b0,
        idx_lvl: LVL_PML4, chk_present: 1'b0, huge_en: 1'b0, huge_1g: 1'b0,
        leaf: 1'b0, next: ST_IDLE
    };

    function automatic t_uop uop_rom(input t_step step);
        t_uop u;
        u = UOP_NOP;
        unique case (step)
            ST_IDLE: begin
                u.dispatch = 1'b1;
            end
            ST_WRITE: begin
                u.wr_en = 1'b1;
            end
            ST_ROOT: begin
                u.chk_root = 1'b1;
                u.rd_en    = 1'b1;
                u.rd_root  = 1'b1;
                u.idx_lvl  = LVL_PML4;
                u.next     = ST_PML4;
            end
            ST_PML4: begin
                u.chk_present = 1'b1;
                u.rd_en       = 1'b1;
                u.idx_lvl     = LVL_PDPT;
                u.next        = ST_PDPT;
            end
            ST_PDPT: begin
                u.chk_present = 1'b1;
                u.huge_en     = 1'b1;
                u.huge_1g     = 1'b1;
                u.rd_en       = 1'b1;
                u.idx_lvl     = LVL_PD;
                u.next        = ST_PD;
            end
            ST_PD: begin
                u.chk_present = 1'b1;
                u.huge_en     = 1'b1;
                u.rd_en       = 1'b1;
                u.idx_lvl     = LVL_PT;
                u.next        = ST_PT;
            end
            ST_PT: begin
                u.chk_present = 1'b1;
                u.leaf        = 1'b1;
            end
            default: begin
                u = UOP_NOP;
            end
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/four_level_page_walk.sv =====
// Top level of the four-level page walker: config registers and wiring.
// Depends on flpw_pkg, flpw_ram, flpw_useq and flpw_dpath.
//
//  channel   ports                                   transfer
//  command   i_start, o_busy, i_item                 start & !busy
//  result    o_done, o_result                        o_done, one cycle
//  config    i_cfg_we, i_cfg_idx, i_cfg_wdata        i_cfg_we
//
// A write transaction passes through the WRITE step before the next can be taken.
// A translation makes up to four dependent table reads through the single
// registered read port of the table RAM, one step each; the result strobe is
// registered and comes in the cycle after the last step, while busy already drops.
// Reset clears control state and config; table RAM is not cleared.
// The receiver cannot stall: o_done is high for exactly one cycle per result.
`default_nettype none

module four_level_page_walk #(
    parameter int MEM_WORDS = 16384
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  flpw_pkg::t_in_item                   i_item,
    output logic                                 o_busy,
    output logic                                 o_done,
    output flpw_pkg::t_out_item                  o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [flpw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [flpw_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int AW = $clog2(MEM_WORDS);

    logic                            r_root_valid;
    logic [flpw_pkg::CFG_DATA_W-1:0] r_root_frame;

    flpw_pkg::t_uop  uop;
    flpw_pkg::t_stat stat;
    logic            busy;
    logic            load;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [63:0]     ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [63:0]     ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_valid <= 1'b0;
            r_root_frame <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                flpw_pkg::CFG_ROOT_VALID: r_root_valid <= i_cfg_wdata[0];
                flpw_pkg::CFG_ROOT_FRAME: r_root_frame <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign load = i_start & ~busy;

    flpw_useq u_useq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_command (i_item.command),
        .i_stat    (stat),
        .o_uop     (uop),
        .o_busy    (busy)
    );

    flpw_dpath #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_item       (i_item),
        .i_uop        (uop),
        .i_root_valid (r_root_valid),
        .i_root_frame (r_root_frame),
        .o_stat       (stat),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_re     (ram_re),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata),
        .o_done       (o_done),
        .o_result     (o_result)
    );

    flpw_ram #(
        .WIDTH (64),
        .DEPTH (MEM_WORDS),
        .AW    (AW)
    ) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_busy = busy;

endmodule

`default_nettype wire

// ===== rtl/flpw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module flpw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/flpw_useq.sv =====
// Microcode sequencer: step register, control ROM lookup and branches.
// Depends on flpw_pkg and four_level_page_walk_defines.svh.
`default_nettype none
`include "four_level_page_walk_defines.svh"

module flpw_useq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic            i_command,
    input  flpw_pkg::t_stat      i_stat,
    output flpw_pkg::t_uop       o_uop,
    output logic                 o_busy
);

    flpw_pkg::t_step r_step;
    flpw_pkg::t_step n_step;
    flpw_pkg::t_uop  uop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= flpw_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        uop = flpw_pkg::uop_rom(r_step);
        if (uop.dispatch) begin
            if (!i_start) begin
                n_step = flpw_pkg::ST_IDLE;
            end else if (i_command == flpw_pkg::CMD_WRITE) begin
                n_step = flpw_pkg::ST_WRITE;
            end else begin
                n_step = flpw_pkg::ST_ROOT;
            end
        end else if (i_stat.finish) begin
            n_step = flpw_pkg::ST_IDLE;
        end else begin
            n_step = uop.next;
        end
    end

    assign o_uop  = uop;
    assign o_busy = (r_step != flpw_pkg::ST_IDLE);

    `FLPW_ASSERT_NEXT(a_start_leaves_idle, (r_step == flpw_pkg::ST_IDLE) && i_start, r_step != flpw_pkg::ST_IDLE, "accepted transaction did not start")
    `FLPW_ASSERT_NEXT(a_pt_ends_walk, r_step == flpw_pkg::ST_PT, r_step == flpw_pkg::ST_IDLE, "walk ran past the PT step")
    `FLPW_ASSERT_NEXT(a_write_one_step, r_step == flpw_pkg::ST_WRITE, r_step == flpw_pkg::ST_IDLE, "write took more than one step")
    `FLPW_ASSERT_NOW(a_no_finish_outside_walk, (r_step == flpw_pkg::ST_IDLE) || (r_step == flpw_pkg::ST_WRITE), !i_stat.finish, "walk finish outside a walk step")

endmodule

`default_nettype wire

// ===== rtl/flpw_dpath.sv =====
// Walker datapath: item latch, table address and checks, result register.
// Depends on flpw_pkg; drives the table RAM ports.
`default_nettype none

module flpw_dpath #(
    parameter int MEM_WORDS = 16384,
    parameter int AW        = $clog2(MEM_WORDS)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_load,
    input  flpw_pkg::t_in_item                   i_item,
    input  flpw_pkg::t_uop                       i_uop,
    input  wire logic                            i_root_valid,
    input  wire logic [flpw_pkg::CFG_DATA_W-1:0] i_root_frame,
    output flpw_pkg::t_stat                      o_stat,
    output logic                                 o_ram_we,
    output logic [AW-1:0]                        o_ram_waddr,
    output logic [63:0]                          o_ram_wdata,
    output logic                                 o_ram_re,
    output logic [AW-1:0]                        o_ram_raddr,
    input  wire logic [63:0]                     i_ram_rdata,
    output logic                                 o_done,
    output flpw_pkg::t_out_item                  o_result
);

    localparam int NUM_TABLES = MEM_WORDS / flpw_pkg::TABLE_ENTRIES;
    localparam int WCMP_W     = 21;
    localparam int ADDR_FW    = flpw_pkg::FRAME_W + flpw_pkg::IDX_W;

    flpw_pkg::t_in_item  r_item;
    logic                r_done;
    flpw_pkg::t_out_item r_result;
    flpw_pkg::t_out_item n_result;

    logic [63:0]                    va;
    logic [63:0]                    ent;
    logic                           canon;
    logic [flpw_pkg::FRAME_W-1:0]   frame_sel;
    logic [flpw_pkg::IDX_W-1:0]     idx;
    logic [ADDR_FW-1:0]             addr_full;
    logic                           bound_ok;
    logic                           huge_hit;
    logic                           leaf_hit;
    logic                           fault;
    logic                           finish;
    logic [WCMP_W-1:0]              widx;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign va  = r_item.virt_addr;
    assign ent = i_ram_rdata;

    // bits 63..47 must all match bit 47
    assign canon = (&va[63:47]) | ~(|va[63:47]);

    always_comb begin
        case (i_uop.idx_lvl)
            flpw_pkg::LVL_PML4: idx = va[47:39];
            flpw_pkg::LVL_PDPT: idx = va[38:30];
            flpw_pkg::LVL_PD:   idx = va[29:21];
            flpw_pkg::LVL_PT:   idx = va[20:12];
            default:            idx = va[47:39];
        endcase
    end

    assign frame_sel = i_uop.rd_root ? flpw_pkg::FRAME_W'(i_root_frame) : ent[51:12];
    assign bound_ok  = frame_sel < flpw_pkg::FRAME_W'(NUM_TABLES);
    assign addr_full = {frame_sel, idx};

    assign huge_hit = i_uop.huge_en & ent[0] & ent[7];
    assign leaf_hit = i_uop.leaf & ent[0];

    // present check first, then page size, then bound of the next table
    assign fault = (i_uop.chk_root & ~(i_root_valid & canon))
                 | (i_uop.chk_present & ~ent[0])
                 | (i_uop.rd_en & ~huge_hit & ~bound_ok);
    assign finish = fault | huge_hit | leaf_hit;

    assign o_stat.finish = finish;
    assign o_ram_re      = i_uop.rd_en & ~finish;
    assign o_ram_raddr   = addr_full[AW-1:0];

    assign widx        = WCMP_W'(r_item.word_index);
    assign o_ram_we    = i_uop.wr_en & (widx < WCMP_W'(MEM_WORDS));
    assign o_ram_waddr = widx[AW-1:0];
    assign o_ram_wdata = r_item.word_data;

    always_comb begin
        n_result.mapped = ~fault;
        if (fault) begin
            n_result.phys_addr = '0;
        end else if (huge_hit && i_uop.huge_1g) begin
            n_result.phys_addr = {ent[51:30], va[29:0]};
        end else if (huge_hit) begin
            n_result.phys_addr = {ent[51:21], va[20:0]};
        end else begin
            n_result.phys_addr = {ent[51:12], va[11:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire
